// ----- hdl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define RPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal keeps its value in the cycle after the condition
`define RPR_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

// ----- hdl/rpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared constants, register indexes and result packing for the range pixel
// reprojection core.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int PIXEL_COORD_BITS_DEF = 12;

    localparam int CENTER_W = 12;
    localparam int FOCAL_W  = 24;
    localparam int RANGE_W  = 31;
    localparam int POINT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CENTER_W-1:0] CENTER_COL_RST = 12'd320;
    localparam logic [CENTER_W-1:0] CENTER_ROW_RST = 12'd240;
    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST    = 24'd153600;
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST    = 24'd153600;
    localparam logic [FOCAL_W-1:0]  FOCAL_MIN      = 24'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd3;

    localparam logic [POINT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POINT_W-1:0] NEG_MAX = 32'h8000_0000;

    // sign and magnitude to saturated two's complement
    function automatic logic [POINT_W-1:0] sat_pack(input logic neg, input logic ovf,
                                                     input logic [POINT_W-1:0] mag);
        if (ovf) begin
            return neg ? NEG_MAX : POS_MAX;
        end
        if (neg) begin
            return (mag > NEG_MAX) ? NEG_MAX : POINT_W'(32'd0 - mag);
        end
        return (mag > POS_MAX) ? POS_MAX : mag;
    endfunction

endpackage

// ----- hdl/range_pixel_to_point_reprojection_core.sv -----
// ----------------------------------------------------------------------------
// range_pixel_to_point_reprojection_core
// Pinhole reprojection of a range pixel into a Q16.16 point (x lateral,
// y forward, z up).
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and returns one point beat per pixel, in
// order. The pipeline is fully stalled only when the output register holds a
// beat that is not taken. The pipeline is a chain of bit-per-stage units:
// the two offset dividers running side by side (PIXEL_COORD_BITS + 16
// stages), the 32-stage square root, the 31-stage range divider and the
// 32-stage lateral and vertical dividers, plus six single registers
// (offsets, squares, sum, products, overflow check and output).
// Configuration is written through a plain write port and must only change
// while no beat is in flight.
// ----------------------------------------------------------------------------
module range_pixel_to_point_reprojection_core #(
    parameter int PIXEL_COORD_BITS = rpr_pkg::PIXEL_COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // pixel channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [PIXEL_COORD_BITS-1:0]          i_pixel_col,
    input  logic [PIXEL_COORD_BITS-1:0]          i_pixel_row,
    input  logic [rpr_pkg::RANGE_W-1:0]          i_range_m,
    // point channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rpr_pkg::POINT_W-1:0]   o_point_x,
    output logic [rpr_pkg::RANGE_W-1:0]          o_point_y,
    output logic signed [rpr_pkg::POINT_W-1:0]   o_point_z
);

    localparam int P      = PIXEL_COORD_BITS;
    localparam int RW     = rpr_pkg::RANGE_W;
    localparam int FW     = rpr_pkg::FOCAL_W;
    localparam int RA_W   = P + 16;
    localparam int SQ_W   = 2 * RA_W;
    localparam int PR_W   = RW + P;
    localparam int XN_W   = PR_W + 8;
    localparam int SIDE_A = 1 + P + RW;
    localparam int SIDE_B = 1 + P;
    localparam int SIDE_R = 2 + 2 * P + RW;
    localparam int SIDE_Y = 2 + 2 * P;
    localparam int SIDE_X = 2 + RW;

    logic en;

    // ---------------- configuration registers
    logic [rpr_pkg::CENTER_W-1:0] r_center_col, r_center_row;
    logic [FW-1:0]                r_focal_x, r_focal_y;
    logic [FW-1:0]                fx_eff, fy_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= rpr_pkg::CENTER_COL_RST;
            r_center_row <= rpr_pkg::CENTER_ROW_RST;
            r_focal_x    <= rpr_pkg::FOCAL_X_RST;
            r_focal_y    <= rpr_pkg::FOCAL_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rpr_pkg::REG_CENTER_COL: r_center_col <= i_cfg_data[rpr_pkg::CENTER_W-1:0];
                rpr_pkg::REG_CENTER_ROW: r_center_row <= i_cfg_data[rpr_pkg::CENTER_W-1:0];
                rpr_pkg::REG_FOCAL_X:    r_focal_x    <= i_cfg_data[FW-1:0];
                rpr_pkg::REG_FOCAL_Y:    r_focal_y    <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // focal lengths below one pixel count as one pixel
    assign fx_eff = (r_focal_x < rpr_pkg::FOCAL_MIN) ? rpr_pkg::FOCAL_MIN : r_focal_x;
    assign fy_eff = (r_focal_y < rpr_pkg::FOCAL_MIN) ? rpr_pkg::FOCAL_MIN : r_focal_y;

    // ---------------- global advance, output register decides
    logic r_out_valid;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------- stage 1: offsets from the principal point
    logic [P-1:0] cc, cr;
    logic         r1_vld, r1_uneg, r1_vneg;
    logic [P-1:0] r1_um, r1_vm;
    logic [RW-1:0] r1_range;

    assign cc = P'(r_center_col);
    assign cr = P'(r_center_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_uneg  <= i_pixel_col < cc;
            r1_vneg  <= i_pixel_row < cr;
            r1_um    <= (i_pixel_col < cc) ? P'(cc - i_pixel_col) : P'(i_pixel_col - cc);
            r1_vm    <= (i_pixel_row < cr) ? P'(cr - i_pixel_row) : P'(i_pixel_row - cr);
            r1_range <= i_range_m;
        end
    end

    // ---------------- slopes |u|/fx and |v|/fy in Q16
    logic              a_vld, b_vld;
    logic [RA_W-1:0]   ra, rb;
    logic [SIDE_A-1:0] a_side;
    logic [SIDE_B-1:0] b_side;

    rpr_div_pipe #(.NUM_W(P + 24), .DEN_W(FW), .Q_W(RA_W), .SIDE_W(SIDE_A)) u_div_a (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r1_vld),
        .i_num({r1_um, 24'd0}), .i_den(fx_eff), .i_side({r1_uneg, r1_um, r1_range}),
        .o_vld(a_vld), .o_quo(ra), .o_side(a_side)
    );

    rpr_div_pipe #(.NUM_W(P + 24), .DEN_W(FW), .Q_W(RA_W), .SIDE_W(SIDE_B)) u_div_b (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r1_vld),
        .i_num({r1_vm, 24'd0}), .i_den(fy_eff), .i_side({r1_vneg, r1_vm}),
        .o_vld(b_vld), .o_quo(rb), .o_side(b_side)
    );

    // ---------------- stage 2: squares
    logic             r2_vld;
    logic [SQ_W-1:0]  r2_sqa, r2_sqb;
    logic [SIDE_R-1:0] r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= a_vld && b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sqa  <= SQ_W'(ra) * SQ_W'(ra);
            r2_sqb  <= SQ_W'(rb) * SQ_W'(rb);
            r2_side <= {a_side, b_side};
        end
    end

    // ---------------- stage 3: k^2 in Q32, saturated to 64 bits
    logic [65:0]       ksq_sum;
    logic              r3_vld;
    logic [63:0]       r3_ksq;
    logic [SIDE_R-1:0] r3_side;

    assign ksq_sum = 66'(64'h1_0000_0000) + 66'(r2_sqa) + 66'(r2_sqb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ksq  <= (|ksq_sum[65:64]) ? '1 : ksq_sum[63:0];
            r3_side <= r2_side;
        end
    end

    // ---------------- k in Q16
    logic              k_vld;
    logic [31:0]       k_q16;
    logic [SIDE_R-1:0] k_side;
    logic              k_uneg, k_vneg;
    logic [P-1:0]      k_um, k_vm;
    logic [RW-1:0]     k_range;

    rpr_sqrt_pipe #(.SIDE_W(SIDE_R)) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r3_vld), .i_rad(r3_ksq), .i_side(r3_side),
        .o_vld(k_vld), .o_root(k_q16), .o_side(k_side)
    );

    assign {k_uneg, k_um, k_range, k_vneg, k_vm} = k_side;

    // ---------------- forward distance y = range / k
    logic              y_vld;
    logic [RW-1:0]     y_q;
    logic [SIDE_Y-1:0] y_side;
    logic              y_uneg, y_vneg;
    logic [P-1:0]      y_um, y_vm;

    rpr_div_pipe #(.NUM_W(RW + 16), .DEN_W(32), .Q_W(RW), .SIDE_W(SIDE_Y)) u_div_y (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(k_vld),
        .i_num({k_range, 16'd0}), .i_den(k_q16), .i_side({k_uneg, k_um, k_vneg, k_vm}),
        .o_vld(y_vld), .o_quo(y_q), .o_side(y_side)
    );

    assign {y_uneg, y_um, y_vneg, y_vm} = y_side;

    // ---------------- stage 4: y times offsets
    logic            r4_vld, r4_uneg, r4_vneg;
    logic [PR_W-1:0] r4_px, r4_pz;
    logic [RW-1:0]   r4_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= y_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_px   <= PR_W'(y_q) * PR_W'(y_um);
            r4_pz   <= PR_W'(y_q) * PR_W'(y_vm);
            r4_y    <= y_q;
            r4_uneg <= y_uneg;
            r4_vneg <= y_vneg;
        end
    end

    // ---------------- stage 5: overflow check ahead of the last division
    logic [XN_W-1:0] nx, nz;
    logic            ovfx, ovfz;
    logic            r5_vld, r5_uneg, r5_vneg, r5_ovfx, r5_ovfz;
    logic [XN_W-1:0] r5_nx, r5_nz;
    logic [RW-1:0]   r5_y;

    assign nx   = {r4_px, 8'd0};
    assign nz   = {r4_pz, 8'd0};
    assign ovfx = (nx >> 32) >= XN_W'(fx_eff);
    assign ovfz = (nz >> 32) >= XN_W'(fy_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx   <= ovfx ? '0 : nx;
            r5_nz   <= ovfz ? '0 : nz;
            r5_ovfx <= ovfx;
            r5_ovfz <= ovfz;
            r5_uneg <= r4_uneg;
            r5_vneg <= r4_vneg;
            r5_y    <= r4_y;
        end
    end

    // ---------------- lateral and vertical magnitudes
    logic              x_vld, z_vld;
    logic [31:0]       x_q, z_q;
    logic [SIDE_X-1:0] x_side;
    logic [1:0]        z_side;
    logic              x_ovf, x_uneg, z_ovf, z_vneg;
    logic [RW-1:0]     x_y;

    rpr_div_pipe #(.NUM_W(XN_W), .DEN_W(FW), .Q_W(32), .SIDE_W(SIDE_X)) u_div_x (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r5_vld),
        .i_num(r5_nx), .i_den(fx_eff), .i_side({r5_ovfx, r5_uneg, r5_y}),
        .o_vld(x_vld), .o_quo(x_q), .o_side(x_side)
    );

    rpr_div_pipe #(.NUM_W(XN_W), .DEN_W(FW), .Q_W(32), .SIDE_W(2)) u_div_z (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(r5_vld),
        .i_num(r5_nz), .i_den(fy_eff), .i_side({r5_ovfz, r5_vneg}),
        .o_vld(z_vld), .o_quo(z_q), .o_side(z_side)
    );

    assign {x_ovf, x_uneg, x_y} = x_side;
    assign {z_ovf, z_vneg}      = z_side;

    // ---------------- output register, z points up so its sign flips
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= x_vld && z_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_point_x <= rpr_pkg::sat_pack(x_uneg, x_ovf, x_q);
            o_point_y <= x_y;
            o_point_z <= rpr_pkg::sat_pack(!z_vneg, z_ovf, z_q);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/rpr_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rpr_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in Q_W bits. A sideband word travels with each beat.
// ----------------------------------------------------------------------------
module rpr_div_pipe #(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 24,
    parameter int Q_W    = 28,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [1:Q_W];
    logic [DEN_W-1:0]  r_rem  [1:Q_W];
    logic [Q_W-1:0]    r_nq   [1:Q_W];
    logic [DEN_W-1:0]  r_den  [1:Q_W];
    logic [SIDE_W-1:0] r_side [1:Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_step
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [Q_W-1:0]    nq_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic              ge;

        // first stage takes the top dividend bits as partial remainder
        if (i == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = DEN_W'(i_num >> Q_W);
            assign nq_in   = i_num[Q_W-1:0];
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[i];
            assign rem_in  = r_rem[i];
            assign nq_in   = r_nq[i];
            assign den_in  = r_den[i];
            assign side_in = r_side[i];
        end

        // shift in one dividend bit, trial subtract
        assign trial = {rem_in, nq_in[Q_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                r_nq[i+1]   <= {nq_in[Q_W-2:0], ge};
                r_den[i+1]  <= den_in;
                r_side[i+1] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[Q_W];
    assign o_quo  = r_nq[Q_W];
    assign o_side = r_side[Q_W];

endmodule

// ----- hdl/rpr_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// rpr_sqrt_pipe
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// giving the floor of the root. A sideband word travels with each beat.
// ----------------------------------------------------------------------------
module rpr_sqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [63:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STEPS = 32;

    logic              r_vld  [1:STEPS];
    logic [33:0]       r_rem  [1:STEPS];
    logic [31:0]       r_root [1:STEPS];
    logic [63:0]       r_rad  [1:STEPS];
    logic [SIDE_W-1:0] r_side [1:STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic              vld_in;
        logic [33:0]       rem_in;
        logic [31:0]       root_in;
        logic [63:0]       rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [35:0]       trial_rem;
        logic [33:0]       trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[i];
            assign rem_in  = r_rem[i];
            assign root_in = r_root[i];
            assign rad_in  = r_rad[i];
            assign side_in = r_side[i];
        end

        // bring down two radicand bits, try root*4+1
        assign trial_rem = {rem_in, rad_in[63:62]};
        assign trial     = {root_in, 2'b01};
        assign ge        = trial_rem >= {2'b00, trial};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]  <= ge ? 34'(trial_rem - {2'b00, trial}) : trial_rem[33:0];
                r_root[i+1] <= {root_in[30:0], ge};
                r_rad[i+1]  <= {rad_in[61:0], 2'b00};
                r_side[i+1] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_root = r_root[STEPS];
    assign o_side = r_side[STEPS];

endmodule

// ----- hdl/rpr_checker.sv -----
// ----------------------------------------------------------------------------
// rpr_checker
// Port-level checks on the reprojection core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [rpr_pkg::POINT_W-1:0]  o_point_x,
    input logic [rpr_pkg::RANGE_W-1:0]         o_point_y,
    input logic signed [rpr_pkg::POINT_W-1:0]  o_point_z
);

    // an empty output register never blocks the input
    `RPR_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // a waiting result stalls the whole pipe
    `RPR_ASSERT(a_stall_propagates, i_clk, i_rst_n, o_out_valid && !i_out_ready |-> !o_in_ready, "input taken while output stalled")

    // a stalled result beat stays
    `RPR_ASSERT(a_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "output beat dropped")

    `RPR_ASSERT_HOLD(a_point_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, {o_point_x, o_point_y, o_point_z}, "output beat changed while stalled")

endmodule

bind range_pixel_to_point_reprojection_core rpr_checker u_rpr_checker (.*);
